[rtl/sacl_pkg.sv]
// shared constants, types and row layout for the set-associative lru tag controller
package sacl_pkg;

    localparam int MAX_SETS      = 256;
    localparam int MAX_WAYS      = 8;
    localparam int ADDR_BITS     = 24;
    localparam int SET_BITS      = $clog2(MAX_SETS);
    localparam int WAY_BITS      = $clog2(MAX_WAYS);
    localparam int WAY_CNT_BITS  = $clog2(MAX_WAYS + 1);
    localparam int RANK_BITS     = 3;
    localparam int TAG_BITS      = ADDR_BITS;
    localparam int SHIFT_BITS    = $clog2(ADDR_BITS + 1);
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 4;

    localparam logic [CFG_DATA_BITS-1:0] OFFSET_LIMIT = 4'd12;
    localparam logic [CFG_DATA_BITS-1:0] INDEX_LIMIT  = CFG_DATA_BITS'(SET_BITS);
    localparam logic [RANK_BITS-1:0]     RANK_MAX     = '1;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_OFFSET_BITS = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_INDEX_BITS  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WAYS_IN_USE = 2'd2;

    // one memory row holds a whole set
    typedef struct packed {
        logic [MAX_WAYS-1:0]                vld;
        logic [MAX_WAYS-1:0][TAG_BITS-1:0]  tag;
        logic [MAX_WAYS-1:0][RANK_BITS-1:0] rank;
    } t_row;

    localparam int ROW_BITS = $bits(t_row);

    // controller to datapath commands
    typedef struct packed {
        logic load;    // latch the access and read its set
        logic finish;  // resolve, write back the set unless a store misses, latch the result
    } t_cmd;

endpackage

[rtl/sacl_if.sv]
// valid/ready channel interfaces for access, result and configuration transfers
interface sacl_req_if;
    logic                             valid;
    logic                             ready;
    logic                             op;
    logic [sacl_pkg::ADDR_BITS-1:0]   address;

    modport source (output valid, output op, output address, input ready);
    modport sink   (input valid, input op, input address, output ready);
endinterface

interface sacl_rsp_if;
    logic                             valid;
    logic                             ready;
    logic                             hit;
    logic [sacl_pkg::WAY_BITS-1:0]    way;

    modport source (output valid, output hit, output way, input ready);
    modport sink   (input valid, input hit, input way, output ready);
endinterface

interface sacl_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [sacl_pkg::CFG_IDX_BITS-1:0]    index;
    logic [sacl_pkg::CFG_DATA_BITS-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/sacl_ram.sv]
// generic single-write, single-read ram with registered read data
module sacl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/sacl_ctrl.sv]
// sequencing state machine and result-valid handshake control
module sacl_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    output logic             o_rsp_valid,
    input  logic             i_rsp_ready,
    output sacl_pkg::t_cmd   o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_LOOK = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_rsp_vld, n_rsp_vld;
    logic   rsp_free;

    // result slot is free when empty or its transfer completes now
    assign rsp_free = !r_rsp_vld || i_rsp_ready;

    always_comb begin
        n_state      = r_state;
        n_rsp_vld    = r_rsp_vld && !i_rsp_ready;
        o_cmd.load   = 1'b0;
        o_cmd.finish = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_LOOK;
                end
            end
            S_LOOK: begin
                if (rsp_free) begin
                    o_cmd.finish = 1'b1;
                    n_rsp_vld    = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rsp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rsp_vld <= n_rsp_vld;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_rsp_vld;

endmodule

[rtl/sacl_dp.sv]
// datapath: config registers, address split, set memory, hit/victim/lru update
module sacl_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    sacl_cfg_if.sink                        i_cfg,
    input  sacl_pkg::t_cmd                  i_cmd,
    input  logic                            i_op,
    input  logic [sacl_pkg::ADDR_BITS-1:0]  i_address,
    output logic                            o_hit,
    output logic [sacl_pkg::WAY_BITS-1:0]   o_way
);

    localparam int AW = sacl_pkg::ADDR_BITS;
    localparam int NW = sacl_pkg::MAX_WAYS;
    localparam int WB = sacl_pkg::WAY_BITS;
    localparam int RB = sacl_pkg::RANK_BITS;
    localparam int CB = sacl_pkg::CFG_DATA_BITS;

    // configuration
    logic [CB-1:0] r_cfg_off, r_cfg_idx, r_cfg_ways;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_off  <= '0;
            r_cfg_idx  <= '0;
            r_cfg_ways <= CB'(1);
        end else if (i_cfg.valid) begin
            if (i_cfg.index == sacl_pkg::CFG_OFFSET_BITS) begin
                r_cfg_off <= i_cfg.data;
            end
            if (i_cfg.index == sacl_pkg::CFG_INDEX_BITS) begin
                r_cfg_idx <= i_cfg.data;
            end
            if (i_cfg.index == sacl_pkg::CFG_WAYS_IN_USE) begin
                r_cfg_ways <= i_cfg.data;
            end
        end
    end

    assign i_cfg.ready = 1'b1;

    // address split
    logic [CB-1:0]                       off, idx;
    logic [sacl_pkg::WAY_CNT_BITS-1:0]   ways;
    logic [sacl_pkg::SHIFT_BITS-1:0]     tag_sh;
    logic [AW-1:0]                       set_mask, set_full;
    logic [sacl_pkg::SET_BITS-1:0]       set_sel;
    logic [sacl_pkg::TAG_BITS-1:0]       tag_sel;

    always_comb begin
        off = (r_cfg_off > sacl_pkg::OFFSET_LIMIT) ? sacl_pkg::OFFSET_LIMIT : r_cfg_off;
        idx = (r_cfg_idx > sacl_pkg::INDEX_LIMIT) ? sacl_pkg::INDEX_LIMIT : r_cfg_idx;
        if (r_cfg_ways == '0) begin
            ways = sacl_pkg::WAY_CNT_BITS'(1);
        end else if (r_cfg_ways > CB'(NW)) begin
            ways = sacl_pkg::WAY_CNT_BITS'(NW);
        end else begin
            ways = sacl_pkg::WAY_CNT_BITS'(r_cfg_ways);
        end
        tag_sh   = sacl_pkg::SHIFT_BITS'(off) + sacl_pkg::SHIFT_BITS'(idx);
        set_mask = (AW'(1) << idx) - AW'(1);
        set_full = (i_address >> off) & set_mask;
        set_sel  = set_full[sacl_pkg::SET_BITS-1:0];
        tag_sel  = sacl_pkg::TAG_BITS'(i_address >> tag_sh);
    end

    // latched access
    logic                               r_store;
    logic [sacl_pkg::SET_BITS-1:0]      r_set;
    logic [sacl_pkg::TAG_BITS-1:0]      r_tag;
    logic [sacl_pkg::WAY_CNT_BITS-1:0]  r_ways;
    logic                               r_row_hot;

    // a row never written reads as all invalid with zero ranks
    logic [sacl_pkg::MAX_SETS-1:0] r_row_ok;

    logic                          wr_en;
    sacl_pkg::t_row                rd_row, row, new_row;
    logic [sacl_pkg::ROW_BITS-1:0] rd_data;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_store   <= i_op;
            r_set     <= set_sel;
            r_tag     <= tag_sel;
            r_ways    <= ways;
            r_row_hot <= r_row_ok[set_sel];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_ok <= '0;
        end else if (wr_en) begin
            r_row_ok[r_set] <= 1'b1;
        end
    end

    sacl_ram #(
        .WIDTH (sacl_pkg::ROW_BITS),
        .DEPTH (sacl_pkg::MAX_SETS)
    ) u_set_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_set),
        .i_wr_data (new_row),
        .i_rd_en   (i_cmd.load),
        .i_rd_addr (set_sel),
        .o_rd_data (rd_data)
    );

    assign rd_row = sacl_pkg::t_row'(rd_data);

    // lookup and update of the set
    logic [NW-1:0] in_use;
    logic          hit, hit_found, inv_found;
    logic [WB-1:0] hit_way, inv_way, vic_way, way_sel;
    logic [RB-1:0] vic_rank, mine;
    logic          fill_inv;

    always_comb begin
        row = rd_row;
        if (!r_row_hot) begin
            row.vld  = '0;
            row.rank = '0;
        end
        for (int i = 0; i < NW; i++) begin
            in_use[i] = (sacl_pkg::WAY_CNT_BITS'(i) < r_ways);
        end

        hit_found = 1'b0;
        hit_way   = '0;
        inv_found = 1'b0;
        inv_way   = '0;
        vic_way   = '0;
        vic_rank  = row.rank[0];
        for (int i = 0; i < NW; i++) begin
            if (!hit_found && in_use[i] && row.vld[i] && row.tag[i] == r_tag) begin
                hit_found = 1'b1;
                hit_way   = WB'(i);
            end
            if (!inv_found && in_use[i] && !row.vld[i]) begin
                inv_found = 1'b1;
                inv_way   = WB'(i);
            end
            // strict compare keeps the lowest way on a tie
            if (i > 0 && in_use[i] && row.rank[i] > vic_rank) begin
                vic_rank = row.rank[i];
                vic_way  = WB'(i);
            end
        end

        hit      = hit_found;
        fill_inv = !hit_found && inv_found;
        if (hit_found) begin
            way_sel = hit_way;
        end else if (r_store) begin
            way_sel = '0;
        end else if (inv_found) begin
            way_sel = inv_way;
        end else begin
            way_sel = vic_way;
        end

        mine    = row.rank[way_sel];
        new_row = row;
        for (int i = 0; i < NW; i++) begin
            if (in_use[i] && WB'(i) != way_sel && row.vld[i]) begin
                if (fill_inv) begin
                    if (row.rank[i] < sacl_pkg::RANK_MAX) begin
                        new_row.rank[i] = row.rank[i] + RB'(1);
                    end
                end else if (row.rank[i] < mine) begin
                    new_row.rank[i] = row.rank[i] + RB'(1);
                end
            end
        end
        new_row.rank[way_sel] = '0;
        new_row.vld[way_sel]  = 1'b1;
        new_row.tag[way_sel]  = r_tag;

        // a store miss leaves the set untouched
        wr_en = i_cmd.finish && (hit || !r_store);
    end

    // result register
    logic          r_hit;
    logic [WB-1:0] r_way;

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_hit <= hit;
            r_way <= way_sel;
        end
    end

    assign o_hit = r_hit;
    assign o_way = r_way;

endmodule

[rtl/set_assoc_cache_lru_tags.sv]
// top level of the set-associative cache tag and true-lru replacement controller
// the set is read at the access transfer edge, then resolved and written back with the result
// registered and marked valid once the result slot is free
// one access at a time: the next waits for the read-modify-write of the set memory row
// a result waiting in the output register does not block the next access transfer
// reset clears configuration to offset 0, index 0, one way, and marks every set empty at once
module set_assoc_cache_lru_tags (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sacl_req_if.sink    i_req,
    sacl_rsp_if.source  o_rsp,
    sacl_cfg_if.sink    i_cfg
);

    sacl_pkg::t_cmd cmd;

    sacl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .o_cmd       (cmd)
    );

    sacl_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (i_cfg),
        .i_cmd     (cmd),
        .i_op      (i_req.op),
        .i_address (i_req.address),
        .o_hit     (o_rsp.hit),
        .o_way     (o_rsp.way)
    );

endmodule
